// ===== hdl/cds_pkg.sv =====
// ----------------------------------------------------------------------------
// cds_pkg: shared types and constants of the calendar date stepper
// Command codes, sequencer states, calendar limits and the month length table.
// ----------------------------------------------------------------------------
package cds_pkg;

  localparam int COUNT_WIDTH_DEF = 12;

  localparam int DAY_W       = 5;
  localparam int MONTH_W     = 4;
  localparam int YEAR_W      = 14;
  localparam int CMD_W       = 2;
  localparam int COUNT_FLD_W = 12;

  localparam logic [YEAR_W-1:0]  YEAR_FLOOR = 14'd1900;
  localparam logic [YEAR_W-1:0]  YEAR_TOP   = 14'd16383;
  localparam logic [MONTH_W-1:0] MONTH_JAN  = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB  = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_DEC  = 4'd12;
  localparam logic [DAY_W-1:0]   DAY_FIRST  = 5'd1;
  localparam logic [DAY_W-1:0]   DAY_LAST   = 5'd31;

  // Multiplicative inverse of 25 modulo 2^14; y*INV mod 2^14 <= LIMIT iff 25 divides y
  localparam logic [YEAR_W-1:0] INV25_MOD   = 14'd7209;
  localparam logic [YEAR_W-1:0] DIV25_LIMIT = 14'd655;

  typedef enum logic [CMD_W-1:0] {
    CMD_SET     = 2'd0,
    CMD_ADVANCE = 2'd1,
    CMD_BACK    = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_VERIFY,
    S_STEP,
    S_FINISH
  } state_t;

  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
    logic [DAY_W-1:0] len;
    case (m)
      4'd2:                   len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
      default:                len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

// ===== hdl/calendar_date_stepper.sv =====
// ----------------------------------------------------------------------------
// calendar_date_stepper: held Gregorian date with set, advance and go back
// Iterative sequencer that steps the date one day per cycle.
// ----------------------------------------------------------------------------
// Usage: send one item on in_* (cmd, new_day, new_month, new_year, day_count).
// Each item yields one result item on out_* carrying the held date after the
// command, the accepted flag and the floor flag (date is 01/01/1900).
// Set checks the proposed date through the shared leap unit, in S_CHECK and
// then S_VERIFY, and loads it only if valid. Advance and go back run one day
// per cycle through the shared day stepper, so the day count sets how many
// steps an item takes. The default count width is 12 bits.
// in_tready is high only while the sequencer is idle; one item is at work at
// a time. A finished result sits in the output register, and the next item
// is accepted meanwhile; if the receiver still stalls when that item ends,
// the sequencer waits in its last state until the output register is free.
// Reset (rst_n low, synchronous) loads 01/01/1900 and empties the output.
// ----------------------------------------------------------------------------
module calendar_date_stepper #(
  parameter int COUNT_WIDTH = cds_pkg::COUNT_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // cmd[1:0], new_day[6:2], new_month[10:7], new_year[24:11], day_count[36:25]
  input  logic [39:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // day[4:0], month[8:5], year[22:9], accepted[23], at_floor[24]
  output logic [31:0] out_tdata
);

  localparam int DW = cds_pkg::DAY_W;
  localparam int MW = cds_pkg::MONTH_W;
  localparam int YW = cds_pkg::YEAR_W;

  cds_pkg::state_t state_r, state_nxt;

  logic [cds_pkg::CMD_W-1:0] cmd_r, cmd_nxt;
  logic [DW-1:0]             nd_r, nd_nxt;
  logic [MW-1:0]             nm_r, nm_nxt;
  logic [YW-1:0]             ny_r, ny_nxt;
  logic [COUNT_WIDTH-1:0]    cnt_r, cnt_nxt;
  logic                      acc_r, acc_nxt;

  logic [DW-1:0] cur_day_r, cur_day_nxt;
  logic [MW-1:0] cur_month_r, cur_month_nxt;
  logic [YW-1:0] cur_year_r, cur_year_nxt;
  logic          leap_r;

  logic          out_valid_r, out_valid_nxt;
  logic [DW-1:0] out_day_r;
  logic [MW-1:0] out_month_r;
  logic [YW-1:0] out_year_r;
  logic          out_acc_r;
  logic          out_floor_r;

  logic [YW-1:0] leap_year;
  logic          leap_c;
  logic          accept;
  logic          out_free;
  logic          load_out;
  logic          use_new_year;
  logic          do_step;
  logic          cnt_zero;
  logic          set_ok;
  logic          at_top;
  logic          at_floor;
  logic [DW-1:0] cur_len;
  logic [DW-1:0] prev_len;
  logic [DW-1:0] new_len;
  logic [cds_pkg::CMD_W-1:0] in_cmd;

  assign in_cmd   = in_tdata[1:0];
  assign accept   = in_tvalid && in_tready;
  assign out_free = !out_valid_r || out_tready;
  assign cnt_zero = (cnt_r == '0);

  // Shared leap unit: new year during the set check, held year otherwise
  assign leap_year = use_new_year ? ny_r : cur_year_r;

  cds_leap u_leap (
    .year (leap_year),
    .leap (leap_c)
  );

  assign cur_len  = cds_pkg::month_len(cur_month_r, leap_r);
  assign prev_len = cds_pkg::month_len(cur_month_r - MW'(1), leap_r);
  assign new_len  = cds_pkg::month_len(nm_r, leap_r);

  assign set_ok = (ny_r >= cds_pkg::YEAR_FLOOR) && (nm_r >= cds_pkg::MONTH_JAN) &&
                  (nm_r <= cds_pkg::MONTH_DEC) && (nd_r >= cds_pkg::DAY_FIRST) &&
                  (nd_r <= new_len);

  assign at_top   = (cur_year_r == cds_pkg::YEAR_TOP) && (cur_month_r == cds_pkg::MONTH_DEC) &&
                    (cur_day_r == cds_pkg::DAY_LAST);
  assign at_floor = (cur_year_r == cds_pkg::YEAR_FLOOR) &&
                    (cur_month_r == cds_pkg::MONTH_JAN) && (cur_day_r == cds_pkg::DAY_FIRST);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      cds_pkg::S_IDLE: begin
        if (accept) begin
          case (in_cmd)
            cds_pkg::CMD_SET:                    state_nxt = cds_pkg::S_CHECK;
            cds_pkg::CMD_ADVANCE, cds_pkg::CMD_BACK: state_nxt = cds_pkg::S_STEP;
            default:                             state_nxt = cds_pkg::S_FINISH;
          endcase
        end
      end
      cds_pkg::S_CHECK:  state_nxt = cds_pkg::S_VERIFY;
      cds_pkg::S_VERIFY: state_nxt = cds_pkg::S_FINISH;
      cds_pkg::S_STEP: begin
        if (cnt_zero) state_nxt = cds_pkg::S_FINISH;
      end
      cds_pkg::S_FINISH: begin
        if (out_free) state_nxt = cds_pkg::S_IDLE;
      end
      default: state_nxt = cds_pkg::S_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_tready    = 1'b0;
    use_new_year = 1'b0;
    do_step      = 1'b0;
    load_out     = 1'b0;
    case (state_r)
      cds_pkg::S_IDLE:   in_tready    = 1'b1;
      cds_pkg::S_CHECK:  use_new_year = 1'b1;
      cds_pkg::S_VERIFY: ;
      cds_pkg::S_STEP:   do_step      = !cnt_zero;
      cds_pkg::S_FINISH: load_out     = out_free;
      default: ;
    endcase
  end

  // Datapath
  always_comb begin
    cmd_nxt       = cmd_r;
    nd_nxt        = nd_r;
    nm_nxt        = nm_r;
    ny_nxt        = ny_r;
    cnt_nxt       = cnt_r;
    acc_nxt       = acc_r;
    cur_day_nxt   = cur_day_r;
    cur_month_nxt = cur_month_r;
    cur_year_nxt  = cur_year_r;
    out_valid_nxt = out_valid_r;

    if (accept) begin
      cmd_nxt = in_cmd;
      nd_nxt  = in_tdata[6:2];
      nm_nxt  = in_tdata[10:7];
      ny_nxt  = in_tdata[24:11];
      cnt_nxt = COUNT_WIDTH'(in_tdata[36:25]);
      acc_nxt = (in_cmd == cds_pkg::CMD_ADVANCE) || (in_cmd == cds_pkg::CMD_BACK);
    end

    if (state_r == cds_pkg::S_VERIFY && set_ok) begin
      cur_day_nxt   = nd_r;
      cur_month_nxt = nm_r;
      cur_year_nxt  = ny_r;
      acc_nxt       = 1'b1;
    end

    if (do_step) begin
      cnt_nxt = cnt_r - COUNT_WIDTH'(1);
      if (cmd_r == cds_pkg::CMD_ADVANCE) begin
        // hold at the top date
        if (!at_top) begin
          if (cur_day_r < cur_len) begin
            cur_day_nxt = cur_day_r + DW'(1);
          end else begin
            cur_day_nxt = cds_pkg::DAY_FIRST;
            if (cur_month_r == cds_pkg::MONTH_DEC) begin
              cur_month_nxt = cds_pkg::MONTH_JAN;
              cur_year_nxt  = cur_year_r + YW'(1);
            end else begin
              cur_month_nxt = cur_month_r + MW'(1);
            end
          end
        end
      end else begin
        // stop at the floor date
        if (!(cur_year_r < cds_pkg::YEAR_FLOOR) && !at_floor) begin
          if (cur_day_r > cds_pkg::DAY_FIRST) begin
            cur_day_nxt = cur_day_r - DW'(1);
          end else if (cur_month_r == cds_pkg::MONTH_JAN) begin
            cur_month_nxt = cds_pkg::MONTH_DEC;
            cur_day_nxt   = cds_pkg::DAY_LAST;
            cur_year_nxt  = cur_year_r - YW'(1);
          end else begin
            cur_month_nxt = cur_month_r - MW'(1);
            cur_day_nxt   = prev_len;
          end
        end
      end
    end

    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cds_pkg::S_IDLE;
      cur_day_r   <= cds_pkg::DAY_FIRST;
      cur_month_r <= cds_pkg::MONTH_JAN;
      cur_year_r  <= cds_pkg::YEAR_FLOOR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cur_day_r   <= cur_day_nxt;
      cur_month_r <= cur_month_nxt;
      cur_year_r  <= cur_year_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r  <= cmd_nxt;
    nd_r   <= nd_nxt;
    nm_r   <= nm_nxt;
    ny_r   <= ny_nxt;
    cnt_r  <= cnt_nxt;
    acc_r  <= acc_nxt;
    leap_r <= leap_c;
    if (load_out) begin
      out_day_r   <= cur_day_r;
      out_month_r <= cur_month_r;
      out_year_r  <= cur_year_r;
      out_acc_r   <= acc_r;
      out_floor_r <= at_floor;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_floor_r, out_acc_r, out_year_r, out_month_r, out_day_r};

endmodule

// ===== hdl/cds_leap.sv =====
// ----------------------------------------------------------------------------
// cds_leap: Gregorian leap year test
// Divisible by 4 and not by 100, or by 400; the test for 25 uses a modular
// inverse multiply instead of a divider.
// ----------------------------------------------------------------------------
module cds_leap (
  input  logic [cds_pkg::YEAR_W-1:0] year,
  output logic                       leap
);

  logic [2*cds_pkg::YEAR_W-1:0] prod_full;
  logic [cds_pkg::YEAR_W-1:0]   prod;
  logic                         div25;

  assign prod_full = year * cds_pkg::INV25_MOD;
  assign prod      = prod_full[cds_pkg::YEAR_W-1:0];
  assign div25     = (prod <= cds_pkg::DIV25_LIMIT);

  // leap = div by 4 and (not div by 100, or div by 400)
  assign leap = (year[1:0] == 2'b00) && (!div25 || (year[3:0] == 4'b0000));

endmodule

// ===== hdl/cds_checker.sv =====
// ----------------------------------------------------------------------------
// cds_checker: port-level checks of the calendar date stepper
// Watches the stream ports over time; bound to the top level below.
// ----------------------------------------------------------------------------
module cds_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [39:0] in_tdata,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result item changed");

  // Drop the output after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result item valid after reset");

  // One item at a time: busy right after an accept
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second item accepted while busy");

  // Floor flag matches the date, and the date never drops below the floor
  a_floor: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[24] == ((out_tdata[4:0] == 5'd1) && (out_tdata[8:5] == 4'd1) &&
                    (out_tdata[22:9] == 14'd1900))) && (out_tdata[22:9] >= 14'd1900))
    else $error("floor flag or year out of line");

endmodule

bind calendar_date_stepper cds_checker u_cds_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
